// File: sv/sjtr_pkg.sv
`timescale 1ns / 1ps

package sjtr_pkg;

	localparam int WIDE_MAX_DEF = 4096;
	localparam int GLYPH_ROWS   = 16;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 3;

	typedef enum logic [1:0] {
		OP_DRAW,
		OP_LOAD_HALF,
		OP_LOAD_CODE,
		OP_LOAD_ROW
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_RIGHT_LIMIT,
		REG_INK,
		REG_SURFACE_WIDTH,
		REG_SURFACE_HEIGHT,
		REG_WIDE_COUNT
	} cfg_reg_t;

	localparam logic [7:0] LEAD_A_LO = 8'h81;
	localparam logic [7:0] LEAD_A_HI = 8'h9f;
	localparam logic [7:0] LEAD_B_LO = 8'he0;
	localparam logic [7:0] LEAD_B_HI = 8'hef;
	localparam logic signed [15:0] UNCLIPPED = 16'sh7fff;
	localparam logic [15:0] BOX_EDGE = 16'h7ffe;
	localparam logic [15:0] BOX_SIDE = 16'h4002;
	localparam logic [3:0] BOX_TOP = 4'd2;
	localparam logic [3:0] BOX_BOTTOM = 4'd14;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  text_byte;
		logic        last;
		logic [11:0] entry_index;
		logic [3:0]  glyph_row;
		logic [15:0] row_bits;
		logic [15:0] wide_code;
	} in_t;

	typedef struct packed {
		logic signed [15:0] row_x;
		logic signed [15:0] row_y;
		logic [15:0]        pixel_mask;
		logic [7:0]         ink_value;
		logic               width_valid;
		logic [15:0]        drawn_width;
		logic               end_of_run;
	} out_t;

	typedef struct packed {
		logic ready;
		logic start_glyph;
		logic hold_lead;
		logic set_stop;
		logic glyph_init;
		logic search_step;
		logic row_emit;
		logic advance;
		logic width_emit;
	} cmd_t;

	typedef struct packed {
		logic stopped;
		logic pending;
		logic lead;
		logic last;
		logic wide;
		logic fits;
		logic probe_ok;
		logic hit;
		logic row_last;
		logic out_free;
	} sts_t;

	function automatic logic is_lead(input logic [7:0] b);
		return (b >= LEAD_A_LO && b <= LEAD_A_HI) || (b >= LEAD_B_LO && b <= LEAD_B_HI);
	endfunction

	function automatic logic [15:0] box_row(input logic [3:0] r);
		logic [15:0] m;
		if (r == BOX_TOP || r == BOX_BOTTOM) begin
			m = BOX_EDGE;
		end else if (r > BOX_TOP && r < BOX_BOTTOM) begin
			m = BOX_SIDE;
		end else begin
			m = '0;
		end
		return m;
	endfunction

endpackage

// File: sv/sjtr_ctrl.sv
`timescale 1ns / 1ps

module sjtr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          draw_fire,
	input  sjtr_pkg::sts_t sts,
	output sjtr_pkg::cmd_t cmd
);
	import sjtr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CHECK,
		ST_PROBE,
		ST_CMP,
		ST_ROW_RD,
		ST_ROW_WR,
		ST_WIDTH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (draw_fire) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.stopped) begin
					state_d = sts.last ? ST_WIDTH : ST_IDLE;
				end else if (!sts.pending && sts.lead && !sts.last) begin
					cmd.hold_lead = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.start_glyph = 1'b1;
					state_d         = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.fits) begin
					cmd.glyph_init = 1'b1;
					state_d        = sts.wide ? ST_PROBE : ST_ROW_RD;
				end else begin
					cmd.set_stop = 1'b1;
					state_d      = sts.last ? ST_WIDTH : ST_IDLE;
				end
			end
			ST_PROBE: begin
				state_d = sts.probe_ok ? ST_CMP : ST_ROW_RD;
			end
			ST_CMP: begin
				cmd.search_step = 1'b1;
				state_d         = sts.hit ? ST_ROW_RD : ST_PROBE;
			end
			ST_ROW_RD: begin
				state_d = ST_ROW_WR;
			end
			ST_ROW_WR: begin
				if (sts.out_free) begin
					cmd.row_emit = 1'b1;
					if (sts.row_last) begin
						cmd.advance = 1'b1;
						state_d     = sts.last ? ST_WIDTH : ST_IDLE;
					end else begin
						state_d = ST_ROW_RD;
					end
				end
			end
			ST_WIDTH: begin
				if (sts.out_free) begin
					cmd.width_emit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/sjtr_datapath.sv
`timescale 1ns / 1ps

module sjtr_datapath #(
	parameter int WIDE_MAX = sjtr_pkg::WIDE_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sjtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sjtr_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            text_fire,
	input  sjtr_pkg::in_t                   text_data,
	input  sjtr_pkg::cmd_t                  cmd,
	output sjtr_pkg::sts_t                  sts,
	output logic                            row_valid,
	input  logic                            row_ready,
	output sjtr_pkg::out_t                  row_data
);
	import sjtr_pkg::*;

	localparam int IW = (WIDE_MAX > 1) ? $clog2(WIDE_MAX) : 1;
	localparam int CW = $clog2(WIDE_MAX + 1);
	localparam int RW = IW + 4;
	localparam int ROWS_DEPTH = WIDE_MAX * GLYPH_ROWS;

	// configuration
	logic signed [15:0] origin_x_q, origin_y_q, right_limit_q;
	logic [7:0]         ink_q;
	logic [14:0]        surf_w_q, surf_h_q;
	logic [12:0]        wide_count_q;

	// string and glyph state
	logic signed [17:0] pen_x_q;
	logic [7:0]         held_q, byte_q;
	logic               pending_q, stopped_q, last_q, wide_q, found_q;
	logic [15:0]        code_q;
	logic [CW-1:0]      lo_q, hi_q;
	logic [IW-1:0]      entry_q;
	logic [3:0]         row_q;

	// tables
	logic [7:0]  half_mem [4096];
	logic [15:0] code_mem [WIDE_MAX];
	logic [15:0] rows_mem [ROWS_DEPTH];
	logic [7:0]  half_rd_q;
	logic [15:0] code_rd_q, rows_rd_q;

	out_t out_q;
	logic out_valid_q;

	logic [CW:0]        mid_sum;
	logic [CW-1:0]      mid_w;
	logic [IW-1:0]      mid_idx;
	logic [CW-1:0]      hi_init;
	logic               idx_ok;
	logic signed [18:0] lim_s, end_s;
	logic signed [16:0] y_s;
	logic               y_ok;
	logic [15:0]        raw_mask, clip_mask;
	logic [15:0]        width_d;
	logic               out_free;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = mid_sum[CW:1];
	assign mid_idx = IW'(mid_w);
	assign hi_init = (32'(wide_count_q) > 32'(WIDE_MAX)) ? CW'(WIDE_MAX) : CW'(wide_count_q);
	assign idx_ok  = 32'(text_data.entry_index) < 32'(WIDE_MAX);

	assign lim_s = (right_limit_q == UNCLIPPED)
		? ({{3{origin_x_q[15]}}, origin_x_q} + 19'sd65535)
		: {{3{right_limit_q[15]}}, right_limit_q};
	assign end_s = {pen_x_q[17], pen_x_q} + (wide_q ? 19'sd16 : 19'sd8);

	assign y_s  = {origin_y_q[15], origin_y_q} + $signed({13'd0, row_q});
	assign y_ok = !y_s[16] && (y_s < $signed({2'b00, surf_h_q}));

	always_comb begin
		if (!wide_q) begin
			raw_mask = {half_rd_q, 8'h00};
		end else if (found_q) begin
			raw_mask = rows_rd_q;
		end else begin
			raw_mask = box_row(row_q);
		end
	end

	// per-column clip against the surface
	always_comb begin
		logic signed [18:0] x_c;
		for (int c = 0; c < 16; c++) begin
			x_c = {pen_x_q[17], pen_x_q} + 19'(c);
			clip_mask[15-c] = raw_mask[15-c] && y_ok && !x_c[18]
				&& (x_c < $signed({4'd0, surf_w_q}));
		end
	end

	assign width_d  = 16'(pen_x_q - {{2{origin_x_q[15]}}, origin_x_q});
	assign out_free = !out_valid_q || row_ready;

	assign sts.stopped  = stopped_q;
	assign sts.pending  = pending_q;
	assign sts.lead     = is_lead(byte_q);
	assign sts.last     = last_q;
	assign sts.wide     = wide_q;
	assign sts.fits     = !(end_s > lim_s);
	assign sts.probe_ok = lo_q < hi_q;
	assign sts.hit      = code_rd_q == code_q;
	assign sts.row_last = row_q == 4'(GLYPH_ROWS - 1);
	assign sts.out_free = out_free;

	assign row_valid = out_valid_q;
	assign row_data  = out_q;

	// tables: one write and one registered read each
	always_ff @(posedge clk) begin
		if (text_fire && text_data.operation == OP_LOAD_HALF) begin
			half_mem[{text_data.text_byte, text_data.glyph_row}] <= text_data.row_bits[7:0];
		end
		half_rd_q <= half_mem[{byte_q, row_q}];
	end

	always_ff @(posedge clk) begin
		if (text_fire && text_data.operation == OP_LOAD_CODE && idx_ok) begin
			code_mem[IW'(text_data.entry_index)] <= text_data.wide_code;
		end
		code_rd_q <= code_mem[mid_idx];
	end

	always_ff @(posedge clk) begin
		if (text_fire && text_data.operation == OP_LOAD_ROW && idx_ok) begin
			rows_mem[RW'({IW'(text_data.entry_index), text_data.glyph_row})] <=
				text_data.row_bits;
		end
		rows_rd_q <= rows_mem[RW'({entry_q, row_q})];
	end

	// glyph working registers
	always_ff @(posedge clk) begin
		if (text_fire && text_data.operation == OP_DRAW) begin
			byte_q <= text_data.text_byte;
			last_q <= text_data.last;
		end
		if (cmd.start_glyph) begin
			wide_q <= pending_q;
			code_q <= {held_q, byte_q};
		end
		if (cmd.glyph_init) begin
			lo_q    <= '0;
			hi_q    <= hi_init;
			found_q <= 1'b0;
			row_q   <= '0;
		end
		if (cmd.search_step) begin
			if (code_rd_q == code_q) begin
				found_q <= 1'b1;
				entry_q <= mid_idx;
			end else if (code_rd_q < code_q) begin
				lo_q <= mid_w + 1'b1;
			end else begin
				hi_q <= mid_w;
			end
		end
		if (cmd.row_emit) begin
			row_q <= row_q + 1'b1;
		end
		if (cmd.row_emit) begin
			out_q.row_x       <= pen_x_q[15:0];
			out_q.row_y       <= y_s[15:0];
			out_q.pixel_mask  <= clip_mask;
			out_q.ink_value   <= ink_q;
			out_q.width_valid <= 1'b0;
			out_q.drawn_width <= '0;
			out_q.end_of_run  <= sts.row_last && !last_q;
		end else if (cmd.width_emit) begin
			out_q.row_x       <= '0;
			out_q.row_y       <= '0;
			out_q.pixel_mask  <= '0;
			out_q.ink_value   <= ink_q;
			out_q.width_valid <= 1'b1;
			out_q.drawn_width <= width_d;
			out_q.end_of_run  <= 1'b1;
		end
	end

	// configuration and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			right_limit_q <= UNCLIPPED;
			ink_q         <= 8'd255;
			surf_w_q      <= 15'd320;
			surf_h_q      <= 15'd240;
			wide_count_q  <= '0;
			pen_x_q       <= '0;
			held_q        <= '0;
			pending_q     <= 1'b0;
			stopped_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ORIGIN_X: begin
						origin_x_q <= $signed(cfg_data);
						pen_x_q    <= {{2{cfg_data[15]}}, cfg_data};
					end
					REG_ORIGIN_Y:       origin_y_q    <= $signed(cfg_data);
					REG_RIGHT_LIMIT:    right_limit_q <= $signed(cfg_data);
					REG_INK:            ink_q         <= cfg_data[7:0];
					REG_SURFACE_WIDTH:  surf_w_q      <= cfg_data[14:0];
					REG_SURFACE_HEIGHT: surf_h_q      <= cfg_data[14:0];
					REG_WIDE_COUNT:     wide_count_q  <= cfg_data[12:0];
					default: begin
					end
				endcase
			end
			if (cmd.hold_lead) begin
				held_q    <= byte_q;
				pending_q <= 1'b1;
			end
			if (cmd.start_glyph) begin
				held_q    <= '0;
				pending_q <= 1'b0;
			end
			if (cmd.set_stop) begin
				stopped_q <= 1'b1;
			end
			if (cmd.advance) begin
				pen_x_q <= pen_x_q + (wide_q ? 18'sd16 : 18'sd8);
			end
			if (cmd.width_emit) begin
				pen_x_q   <= {{2{origin_x_q[15]}}, origin_x_q};
				held_q    <= '0;
				pending_q <= 1'b0;
				stopped_q <= 1'b0;
			end
			if (cmd.row_emit || cmd.width_emit) begin
				out_valid_q <= 1'b1;
			end else if (row_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/shift_jis_text_rasterizer.sv
`timescale 1ns / 1ps

// Shift-JIS text rasterizer: takes one operation beat at a time and turns draw
// bytes into 16 row-mask beats per glyph, plus a width beat after the byte
// marked last. Load operations (half-width rows, wide codes, wide rows) can
// arrive back to back. A draw byte that is held as a lead, or that falls in a
// stopped string, goes through accept and decode only; a byte that fails the
// right-limit check goes through the limit check as well. A drawn glyph goes
// through setup (accept, decode, limit check), then for wide glyphs a binary
// search (at most log2(WIDE_MAX)+1 probes, one code-table read and compare
// each, plus a final probe step to end a search that misses), then per row a
// table read then the output register load. The single output register
// decouples the sides; a stalled consumer simply holds the row loop.
// Tables are not cleared at reset: read only entries that were loaded.
module shift_jis_text_rasterizer #(
	parameter int WIDE_MAX = sjtr_pkg::WIDE_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [sjtr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sjtr_pkg::CFG_W-1:0]     cfg_data,
	// operation beats in
	input  logic                           text_valid,
	output logic                           text_ready,
	input  sjtr_pkg::in_t                  text_data,
	// row and width beats out
	output logic                           row_valid,
	input  logic                           row_ready,
	output sjtr_pkg::out_t                 row_data
);
	import sjtr_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic text_fire;
	logic draw_fire;

	// only the idle controller takes a beat
	assign text_ready = cmd.ready;
	assign text_fire  = text_valid && text_ready;
	assign draw_fire  = text_fire && text_data.operation == OP_DRAW;

	sjtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.draw_fire (draw_fire),
		.sts       (sts),
		.cmd       (cmd)
	);

	sjtr_datapath #(
		.WIDE_MAX (WIDE_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text_fire (text_fire),
		.text_data (text_data),
		.cmd       (cmd),
		.sts       (sts),
		.row_valid (row_valid),
		.row_ready (row_ready),
		.row_data  (row_data)
	);

	// a width beat always closes the run of its input
	a_width_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_data.width_valid |-> row_data.end_of_run)
		else $error("width beat without end of run");

	// a width beat carries no pixels
	a_width_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_data.width_valid |-> row_data.pixel_mask == 16'd0)
		else $error("width beat with pixel mask");

	// no new beat is taken while a glyph is being emitted
	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row_emit |-> !text_ready)
		else $error("input taken during row emission");

endmodule
